[rtl/core/bba_pkg.sv]
// Shared types and constants of the bitmap block allocator.
package bba_pkg;

    localparam int IDX_W       = 12;
    localparam int CFG_W       = 13;
    localparam int STAT_W      = 2;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;
    localparam int CFG_RESET   = 4096;

    typedef enum logic
    {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [STAT_W-1:0]
    {
        STAT_OK          = 2'd0,
        STAT_FULL        = 2'd1,
        STAT_DOUBLE_FREE = 2'd2,
        STAT_RANGE       = 2'd3
    } status_t;

    typedef enum logic [2:0]
    {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FREE_ADDR,
        S_FREE_CHK,
        S_DONE
    } state_t;

endpackage

[rtl/core/bba_map_ram.sv]
// Allocation map storage: one write port, one read port, registered read data.
module bba_map_ram #(
    parameter int DEPTH  = 512,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = 9
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

endmodule

[rtl/core/bba_word_scan.sv]
// Finds the lowest clear bit of one map word among the bits still below the count.
module bba_word_scan #(
    parameter int WIDTH = 8,
    parameter int CNT_W = 13,
    parameter int BIT_W = 3
) (
    input  logic [WIDTH-1:0] word,
    input  logic [CNT_W-1:0] remaining,
    output logic             found,
    output logic [BIT_W-1:0] bit_idx
);

    always_comb
    begin
        found   = 1'b0;
        bit_idx = '0;
        // walk down so the lowest hit wins
        for (int b = WIDTH - 1; b >= 0; b--)
        begin
            if (!word[b] && (remaining > CNT_W'(b)))
            begin
                found   = 1'b1;
                bit_idx = BIT_W'(b);
            end
        end
    end

endmodule

[rtl/core/bitmap_block_allocator_unit.sv]
// Top level of the first-fit bitmap block allocator.
//
//  port group       | dir | contents
//  -----------------+-----+------------------------------------------------
//  cfg_*            | in  | blocks_in_use write, 13 bits
//  s_t*             | in  | tuser: command; tdata: block_index [11:0]
//  m_t*             | out | tdata: granted_block [11:0]; tuser: status
//
//  Allocate: map words are read one per cycle through the map RAM read port
//  until a free bit is found or the last word has been scanned. Free: the word
//  holding the index is read and its bit checked; an out-of-range index skips the read.
//  After reset a clearing pass writes every map word (DEPTH words, 512 at
//  default parameters); s_tready stays low until it ends, cfg writes are taken.
//  The output register holds a result until taken; a new beat is accepted
//  meanwhile, and its finish stalls only while that result is still waiting.
module bitmap_block_allocator_unit #(
    parameter int MAX_BLOCKS    = 4096,
    parameter int MAP_WORD_BITS = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bba_pkg::CFG_W-1:0]          cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [bba_pkg::IN_TDATA_W-1:0]     s_tdata,   // block_index [11:0]
    input  logic                               s_tuser,   // command
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [bba_pkg::OUT_TDATA_W-1:0]    m_tdata,   // granted_block [11:0]
    output logic [bba_pkg::STAT_W-1:0]         m_tuser    // status
);

    import bba_pkg::*;

    localparam int DEPTH   = (MAX_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BIT_W   = $clog2(MAP_WORD_BITS);
    localparam int CNT_W   = ($clog2(MAX_BLOCKS + 1) > CFG_W) ? $clog2(MAX_BLOCKS + 1) : CFG_W;
    localparam int SHIFT   = IDX_W + BIT_W;
    localparam int RECIP_W = SHIFT + 1;
    localparam int PROD_W  = IDX_W + RECIP_W;
    localparam int QW_W    = IDX_W + BIT_W + 1;
    localparam int RST_EFF = (CFG_RESET > MAX_BLOCKS) ? MAX_BLOCKS : CFG_RESET;

    localparam logic [RECIP_W-1:0] RECIP     = RECIP_W'((2 ** SHIFT) / MAP_WORD_BITS);
    localparam logic [CNT_W-1:0]   MAX_C     = CNT_W'(MAX_BLOCKS);
    localparam logic [CNT_W-1:0]   W_CNT     = CNT_W'(MAP_WORD_BITS);
    localparam logic [IDX_W-1:0]   W_IDX     = IDX_W'(MAP_WORD_BITS);
    localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [MAP_WORD_BITS-1:0] ONE_BIT = {{(MAP_WORD_BITS-1){1'b0}}, 1'b1};

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       eff_count_reg, eff_count_next;
    logic [ADDR_W-1:0]      clr_addr_reg, clr_addr_next;
    logic                   out_valid_reg, out_valid_next;

    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [IDX_W-1:0]       q_reg, q_next;
    logic [ADDR_W-1:0]      addr_reg, addr_next;
    logic [BIT_W-1:0]       bit_reg, bit_next;
    logic [CNT_W-1:0]       base_reg, base_next;
    logic [IDX_W-1:0]       res_block_reg, res_block_next;
    status_t                res_status_reg, res_status_next;
    logic [IDX_W-1:0]       out_block_reg, out_block_next;
    status_t                out_status_reg, out_status_next;

    logic                      mem_rd_en, mem_wr_en;
    logic [ADDR_W-1:0]         mem_rd_addr, mem_wr_addr;
    logic [MAP_WORD_BITS-1:0]  mem_rd_data, mem_wr_data;

    logic                   in_accept;
    cmd_t                   in_cmd;
    logic [IDX_W-1:0]       in_idx;
    logic [PROD_W-1:0]      recip_prod;
    logic [QW_W-1:0]        qw_prod;
    logic [IDX_W-1:0]       rem, rem_fix, q_fix;
    logic [ADDR_W-1:0]      free_addr;
    logic [BIT_W-1:0]       free_bit;
    logic                   in_range;
    logic                   bit_used;
    logic [CNT_W-1:0]       remaining;
    logic                   last_word;
    logic                   scan_found;
    logic [BIT_W-1:0]       scan_bit;
    logic [CNT_W-1:0]       grant;
    logic [CNT_W-1:0]       cfg_ext;
    logic                   out_load;

    bba_map_ram #(
        .DEPTH  (DEPTH),
        .WIDTH  (MAP_WORD_BITS),
        .ADDR_W (ADDR_W)
    ) u_map (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    bba_word_scan #(
        .WIDTH (MAP_WORD_BITS),
        .CNT_W (CNT_W),
        .BIT_W (BIT_W)
    ) u_scan (
        .word      (mem_rd_data),
        .remaining (remaining),
        .found     (scan_found),
        .bit_idx   (scan_bit)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign in_cmd    = cmd_t'(s_tuser);
    assign in_idx    = s_tdata[IDX_W-1:0];
    assign cfg_ext   = CNT_W'(cfg_data);

    // word index estimate by reciprocal, low by at most one
    assign recip_prod = PROD_W'(in_idx) * PROD_W'(RECIP);

    always_comb
    begin
        qw_prod = QW_W'(q_reg) * QW_W'(MAP_WORD_BITS);
        rem     = idx_reg - qw_prod[IDX_W-1:0];
        if (rem >= W_IDX)
        begin
            q_fix   = q_reg + IDX_W'(1);
            rem_fix = rem - W_IDX;
        end
        else
        begin
            q_fix   = q_reg;
            rem_fix = rem;
        end
    end

    assign free_addr = ADDR_W'(q_fix);
    assign free_bit  = rem_fix[BIT_W-1:0];
    assign in_range  = (CNT_W'(idx_reg) < eff_count_reg);
    assign bit_used  = mem_rd_data[bit_reg];
    assign remaining = eff_count_reg - base_reg;
    assign last_word = (remaining <= W_CNT);
    assign grant     = base_reg + CNT_W'(scan_bit);
    assign out_load  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-IDX_W){1'b0}}, out_block_reg};
    assign m_tuser  = out_status_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (in_cmd == CMD_FREE)
                    begin
                        state_next = S_FREE_ADDR;
                    end
                    else if (eff_count_reg == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_found || last_word)
                begin
                    state_next = S_DONE;
                end
            end
            S_FREE_ADDR:
            begin
                state_next = in_range ? S_FREE_CHK : S_DONE;
            end
            S_FREE_CHK:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        eff_count_next  = eff_count_reg;
        clr_addr_next   = clr_addr_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        idx_next        = idx_reg;
        q_next          = q_reg;
        addr_next       = addr_reg;
        bit_next        = bit_reg;
        base_next       = base_reg;
        res_block_next  = res_block_reg;
        res_status_next = res_status_reg;
        out_block_next  = out_block_reg;
        out_status_next = out_status_reg;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = '0;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = '0;
        mem_wr_data     = '0;

        if (cfg_valid && cfg_ready)
        begin
            eff_count_next = (cfg_ext > MAX_C) ? MAX_C : cfg_ext;
        end

        case (state_reg)
            S_CLEAR:
            begin
                mem_wr_en     = 1'b1;
                mem_wr_addr   = clr_addr_reg;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    res_block_next = '0;
                    if (in_cmd == CMD_FREE)
                    begin
                        idx_next = in_idx;
                        q_next   = recip_prod[SHIFT +: IDX_W];
                    end
                    else
                    begin
                        base_next       = '0;
                        addr_next       = '0;
                        res_status_next = STAT_FULL;
                        if (eff_count_reg != '0)
                        begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = '0;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_found)
                begin
                    mem_wr_en       = 1'b1;
                    mem_wr_addr     = addr_reg;
                    mem_wr_data     = mem_rd_data | (ONE_BIT << scan_bit);
                    res_block_next  = grant[IDX_W-1:0];
                    res_status_next = STAT_OK;
                end
                else if (last_word)
                begin
                    res_status_next = STAT_FULL;
                end
                else
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = addr_reg + ADDR_W'(1);
                    addr_next   = addr_reg + ADDR_W'(1);
                    base_next   = base_reg + W_CNT;
                end
            end
            S_FREE_ADDR:
            begin
                if (in_range)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = free_addr;
                    addr_next   = free_addr;
                    bit_next    = free_bit;
                end
                else
                begin
                    res_status_next = STAT_RANGE;
                end
            end
            S_FREE_CHK:
            begin
                if (bit_used)
                begin
                    mem_wr_en       = 1'b1;
                    mem_wr_addr     = addr_reg;
                    mem_wr_data     = mem_rd_data & ~(ONE_BIT << bit_reg);
                    res_status_next = STAT_OK;
                end
                else
                begin
                    res_status_next = STAT_DOUBLE_FREE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next  = 1'b1;
                    out_block_next  = res_block_reg;
                    out_status_next = res_status_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            eff_count_reg <= CNT_W'(RST_EFF);
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            eff_count_reg <= eff_count_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        q_reg          <= q_next;
        addr_reg       <= addr_next;
        bit_reg        <= bit_next;
        base_reg       <= base_next;
        res_block_reg  <= res_block_next;
        res_status_reg <= res_status_next;
        out_block_reg  <= out_block_next;
        out_status_reg <= out_status_next;
    end

`ifndef SYNTHESIS
    // a granted block always lies below the effective count
    a_grant_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && scan_found) |-> (grant < eff_count_reg))
        else $error("granted block at or above the block count");

    // reciprocal estimate needs at most one correction step
    a_div_fix: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FREE_ADDR) |-> (rem_fix < W_IDX))
        else $error("free word index correction out of range");

    // read and write never hit the same map word in one cycle
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_wr_en && mem_rd_en && (mem_wr_addr == mem_rd_addr)))
        else $error("map read and write collide on one word");

    // a finished result reaches the output register on the next edge
    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_load) |=> (m_tvalid && state_reg == S_IDLE))
        else $error("result not loaded into output register");
`endif

endmodule
